[hdl/erp_pkg.sv]
package erp_pkg;

   // Coordinate format is fixed by the payload structs
   localparam int COORD_W     = 32;
   localparam int ANGLE_REG_W = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_ALPHA = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_BETA  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE_GAMMA = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_X    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_Y    = 3'd4;

   // Rotation-mode CORDIC on a 32-bit turn angle, 30 fraction bits
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_FRAC  = 30;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
      logic                      last_in;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
      logic signed [COORD_W-1:0] rz;
      logic                      last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROTATE,
      ST_STORE,
      ST_PRODUCT,
      ST_MATRIX
   } mstate_type;

   // atan(2^-i) in turn units of 2^32
   function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
      logic signed [31:0] a;
      unique case (i)
         5'd0:  a = 32'sd536870912;
         5'd1:  a = 32'sd316933406;
         5'd2:  a = 32'sd167458907;
         5'd3:  a = 32'sd85004756;
         5'd4:  a = 32'sd42667331;
         5'd5:  a = 32'sd21354465;
         5'd6:  a = 32'sd10679838;
         5'd7:  a = 32'sd5340245;
         5'd8:  a = 32'sd2670163;
         5'd9:  a = 32'sd1335087;
         5'd10: a = 32'sd667544;
         5'd11: a = 32'sd333772;
         5'd12: a = 32'sd166886;
         5'd13: a = 32'sd83443;
         5'd14: a = 32'sd41722;
         5'd15: a = 32'sd20861;
         5'd16: a = 32'sd10430;
         5'd17: a = 32'sd5215;
         5'd18: a = 32'sd2608;
         5'd19: a = 32'sd1304;
         5'd20: a = 32'sd652;
         5'd21: a = 32'sd326;
         5'd22: a = 32'sd163;
         5'd23: a = 32'sd81;
         5'd24: a = 32'sd41;
         5'd25: a = 32'sd20;
         5'd26: a = 32'sd10;
         5'd27: a = 32'sd5;
         5'd28: a = 32'sd3;
         5'd29: a = 32'sd1;
         default: a = 32'sd0;
      endcase
      return a;
   endfunction

endpackage

[hdl/erp_matrix.sv]
module erp_matrix #(
   parameter int ANGLE_WIDTH    = 16,
   parameter int TRIG_FRAC_BITS = 16,
   localparam int MatW          = TRIG_FRAC_BITS + 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [erp_pkg::ANGLE_REG_W-1:0]       angle_alpha,
   input  logic [erp_pkg::ANGLE_REG_W-1:0]       angle_beta,
   input  logic [erp_pkg::ANGLE_REG_W-1:0]       angle_gamma,
   output logic                                  busy,
   output logic signed [MatW-1:0]                mat [9]
);
   import erp_pkg::*;

   localparam int TrigW    = TRIG_FRAC_BITS + 2;
   localparam int RndShift = CORDIC_FRAC - TRIG_FRAC_BITS;
   localparam logic signed [CORDIC_W-1:0] CHALF = CORDIC_W'(1) <<< (RndShift - 1);
   localparam logic signed [CORDIC_W-1:0] CONE  = CORDIC_W'(1) <<< TRIG_FRAC_BITS;
   localparam logic signed [2*TrigW-1:0]  PHALF = (2*TrigW)'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic [3:0] LAST_STEP = 4'd13;

   // trig slots
   localparam int T_SA = 0, T_CA = 1, T_SB = 2, T_CB = 3, T_SG = 4, T_CG = 5;

   mstate_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [4:0] iter_ff, iter_in;
   logic [3:0] step_ff, step_in;
   logic [1:0] quad_ff, quad_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] z_ff, z_in;
   logic signed [TrigW-1:0] trig_ff [6];
   logic signed [TrigW-1:0] trig_in [6];
   logic signed [TrigW-1:0] prod_ff [14];
   logic signed [TrigW-1:0] prod_in [14];
   logic signed [MatW-1:0]  mat_ff [9];
   logic signed [MatW-1:0]  mat_in [9];

   logic [ANGLE_REG_W-1:0] angle;
   logic [31:0] turn;
   logic signed [CORDIC_W-1:0] cs, sn;
   logic signed [TrigW-1:0] op_a, op_b;
   logic signed [2*TrigW-1:0] mprod, mrnd;

   function automatic logic signed [TrigW-1:0] trig_round(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] r;
      r = (v + CHALF) >>> RndShift;
      if (r > CONE)  r = CONE;
      if (r < -CONE) r = -CONE;
      return TrigW'(r);
   endfunction

   always_comb begin
      unique case (sel_ff)
         2'd0:    angle = angle_alpha;
         2'd1:    angle = angle_beta;
         default: angle = angle_gamma;
      endcase
   end

   // angle bits above ANGLE_WIDTH shift out of the turn word
   assign turn = 32'(angle) << (32 - ANGLE_WIDTH);

   always_comb begin
      unique case (quad_ff)
         2'd1:    begin cs = -y_ff; sn = x_ff;  end
         2'd2:    begin cs = -x_ff; sn = -y_ff; end
         2'd3:    begin cs = y_ff;  sn = -x_ff; end
         default: begin cs = x_ff;  sn = y_ff;  end
      endcase
   end

   // operand schedule of the shared multiplier
   always_comb begin
      case (step_ff)
         4'd0:    begin op_a = trig_ff[T_CB]; op_b = trig_ff[T_CG]; end
         4'd1:    begin op_a = trig_ff[T_CB]; op_b = trig_ff[T_SG]; end
         4'd2:    begin op_a = trig_ff[T_CG]; op_b = trig_ff[T_SA]; end
         4'd3:    begin op_a = trig_ff[T_CA]; op_b = trig_ff[T_SG]; end
         4'd4:    begin op_a = trig_ff[T_CA]; op_b = trig_ff[T_CG]; end
         4'd5:    begin op_a = trig_ff[T_SA]; op_b = trig_ff[T_SB]; end
         4'd6:    begin op_a = trig_ff[T_CB]; op_b = trig_ff[T_SA]; end
         4'd7:    begin op_a = trig_ff[T_SA]; op_b = trig_ff[T_SG]; end
         4'd8:    begin op_a = trig_ff[T_CA]; op_b = trig_ff[T_SB]; end
         4'd9:    begin op_a = trig_ff[T_CA]; op_b = trig_ff[T_CB]; end
         4'd10:   begin op_a = prod_ff[2];    op_b = trig_ff[T_SB]; end
         4'd11:   begin op_a = prod_ff[5];    op_b = trig_ff[T_SG]; end
         4'd12:   begin op_a = prod_ff[4];    op_b = trig_ff[T_SB]; end
         default: begin op_a = prod_ff[8];    op_b = trig_ff[T_SG]; end
      endcase
      mprod = op_a * op_b;
      mrnd  = (mprod + PHALF) >>> TRIG_FRAC_BITS;
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      iter_in  = iter_ff;
      step_in  = step_ff;
      quad_in  = quad_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      trig_in  = trig_ff;
      prod_in  = prod_ff;
      mat_in   = mat_ff;
      unique case (state_ff)
         ST_IDLE: ;
         ST_LOAD: begin
            x_in     = CORDIC_GAIN;
            y_in     = '0;
            z_in     = $signed({2'b00, turn[29:0]});
            quad_in  = turn[31:30];
            iter_in  = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (!z_ff[31]) begin
               x_in = x_ff - (y_ff >>> iter_ff);
               y_in = y_ff + (x_ff >>> iter_ff);
               z_in = z_ff - atan_turn(iter_ff);
            end else begin
               x_in = x_ff + (y_ff >>> iter_ff);
               y_in = y_ff - (x_ff >>> iter_ff);
               z_in = z_ff + atan_turn(iter_ff);
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(CORDIC_STEPS - 1)) state_in = ST_STORE;
         end
         ST_STORE: begin
            trig_in[{sel_ff, 1'b0}] = trig_round(sn);
            trig_in[{sel_ff, 1'b1}] = trig_round(cs);
            if (sel_ff == 2'd2) begin
               step_in  = '0;
               state_in = ST_PRODUCT;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         ST_PRODUCT: begin
            prod_in[step_ff] = TrigW'(mrnd);
            step_in = step_ff + 4'd1;
            if (step_ff == LAST_STEP) state_in = ST_MATRIX;
         end
         ST_MATRIX: begin
            mat_in[0] = MatW'(prod_ff[0]);
            mat_in[1] = -MatW'(prod_ff[1]);
            mat_in[2] = MatW'(trig_ff[T_SB]);
            mat_in[3] = MatW'(prod_ff[10]) + MatW'(prod_ff[3]);
            mat_in[4] = MatW'(prod_ff[4]) - MatW'(prod_ff[11]);
            mat_in[5] = -MatW'(prod_ff[6]);
            mat_in[6] = MatW'(prod_ff[7]) - MatW'(prod_ff[12]);
            mat_in[7] = MatW'(prod_ff[2]) + MatW'(prod_ff[13]);
            mat_in[8] = MatW'(prod_ff[9]);
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      // any register write restarts the matrix build
      if (csr_we) begin
         sel_in   = '0;
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      step_ff <= step_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      trig_ff <= trig_in;
      prod_ff <= prod_in;
      mat_ff  <= mat_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign mat  = mat_ff;

endmodule

[hdl/euler_rotate_points.sv]
// Channel   | Ports                        | Direction | Moves
// ----------+------------------------------+-----------+--------------------------------
// input     | start, busy, req_beat        | in        | one point per beat
// result    | rsp_strobe, rsp_beat         | out       | one rotated point per beat
// config    | csr_we, csr_index, csr_wdata | in        | one register write per beat
//
// A point is taken at an edge with start high and busy low, one per cycle.
// Its result moves through the input, product, sum and output stages and then
// raises rsp_strobe; the pipeline has no stall, since the receiver cannot hold
// off a beat. After reset and after every register write, busy stays high while
// one shared CORDIC builds the three angles in turn and one shared multiplier
// then forms the matrix products.
// Reset is synchronous and clears the configuration registers and valid bits.
module euler_rotate_points #(
   parameter int ANGLE_WIDTH    = 16,
   parameter int TRIG_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  erp_pkg::req_type                    req_beat,
   output logic                                rsp_strobe,
   output erp_pkg::rsp_type                    rsp_beat,
   input  logic                                csr_we,
   input  logic [erp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [erp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import erp_pkg::*;

   localparam int MatW = TRIG_FRAC_BITS + 3;
   localparam int DW   = COORD_W + 1;        // centred coordinate
   localparam int PW   = DW + MatW;          // one matrix product
   localparam int SW   = PW + 2;             // row sum of three products
   localparam int RW   = SW + 1;             // with the centre added
   localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [RW-1:0] SAT_MAX =
      {{(RW - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_MIN = ~SAT_MAX;

   // Configuration registers
   logic [ANGLE_REG_W-1:0]    alpha_ff, beta_ff, gamma_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= '0;
         beta_ff  <= '0;
         gamma_ff <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANGLE_ALPHA: alpha_ff <= csr_wdata[ANGLE_REG_W-1:0];
            CSR_ANGLE_BETA:  beta_ff  <= csr_wdata[ANGLE_REG_W-1:0];
            CSR_ANGLE_GAMMA: gamma_ff <= csr_wdata[ANGLE_REG_W-1:0];
            CSR_CENTRE_X:    cx_ff    <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_CENTRE_Y:    cy_ff    <= $signed(csr_wdata[COORD_W-1:0]);
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // Matrix builder: runs after reset and after each write, holds busy
   logic signed [MatW-1:0] mat [9];

   erp_matrix #(
      .ANGLE_WIDTH    (ANGLE_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_matrix (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .angle_alpha (alpha_ff),
      .angle_beta  (beta_ff),
      .angle_gamma (gamma_ff),
      .busy        (busy),
      .mat         (mat)
   );

   logic accept;
   assign accept = start && !busy;

   // Stage 0: centre x and y; z goes in as is
   logic                  v0_ff, last0_ff;
   logic signed [DW-1:0]  d_ff [3];
   logic signed [DW-1:0]  d_in [3];

   assign d_in[0] = DW'(req_beat.px) - DW'(cx_ff);
   assign d_in[1] = DW'(req_beat.py) - DW'(cy_ff);
   assign d_in[2] = DW'(req_beat.pz);

   // Stage 1: nine products
   logic                  v1_ff, last1_ff;
   logic signed [PW-1:0]  pr_ff [9];
   logic signed [PW-1:0]  pr_in [9];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         pr_in[k] = PW'(d_ff[k % 3]) * PW'(mat[k]);
      end
   end

   // Stage 2: row sums with the rounding half
   logic                  v2_ff, last2_ff;
   logic signed [SW-1:0]  sum_ff [3];
   logic signed [SW-1:0]  sum_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SW'(pr_ff[3*r]) + SW'(pr_ff[3*r + 1]) + SW'(pr_ff[3*r + 2]) + HALF;
      end
   end

   // Stage 3: drop the fraction, add the centre back, saturate
   logic signed [RW-1:0]      res   [3];
   logic signed [COORD_W-1:0] res_q [3];
   logic                      v3_ff;
   rsp_type                   rsp_ff, rsp_in;

   always_comb begin
      res[0] = RW'(sum_ff[0] >>> TRIG_FRAC_BITS) + RW'(cx_ff);
      res[1] = RW'(sum_ff[1] >>> TRIG_FRAC_BITS) + RW'(cy_ff);
      res[2] = RW'(sum_ff[2] >>> TRIG_FRAC_BITS);
      for (int r = 0; r < 3; r++) begin
         if (res[r] > SAT_MAX)      res_q[r] = COORD_W'(SAT_MAX);
         else if (res[r] < SAT_MIN) res_q[r] = COORD_W'(SAT_MIN);
         else                       res_q[r] = COORD_W'(res[r]);
      end
      rsp_in.rx       = res_q[0];
      rsp_in.ry       = res_q[1];
      rsp_in.rz       = res_q[2];
      rsp_in.last_out = last2_ff;
   end

   // Valid bits advance every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload advances without reset
   always_ff @(posedge clock) begin
      d_ff     <= d_in;
      last0_ff <= req_beat.last_in;
      pr_ff    <= pr_in;
      last1_ff <= last0_ff;
      sum_ff   <= sum_in;
      last2_ff <= last1_ff;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = v3_ff;
   assign rsp_beat   = rsp_ff;

endmodule

[hdl/erp_checker.sv]
module erp_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input erp_pkg::req_type req_beat,
   input logic             rsp_strobe,
   input erp_pkg::rsp_type rsp_beat,
   input logic             csr_we
);
   import erp_pkg::*;

   // reset leaves the block building its matrix
   a_busy_after_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   // a write starts a rebuild
   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("busy low after a register write");

   // every accepted beat comes out as a result beat
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("accepted beat lost");

   // no result beat comes out without a matching accepted point
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("result beat without an accepted point");

   // the set marker follows its point
   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_beat.last_out == $past(req_beat.last_in, 4)))
      else $error("last marker out of order");

endmodule

bind euler_rotate_points erp_checker u_erp_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_beat   (req_beat),
   .rsp_strobe (rsp_strobe),
   .rsp_beat   (rsp_beat),
   .csr_we     (csr_we)
);

[test/euler_rotate_points_test.sv]
`timescale 1ns / 100ps

// Point stream through the Euler rotation block: a directed table of extreme
// points first, then table rows and random points under angle/centre settings.
// Each result beat is compared with its typed row or a local CORDIC predictor.
module euler_rotate_points_test;
   import erp_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES  = 13;
   localparam int PHASE_POINTS   = 100;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_beat;
   logic                   rsp_strobe;
   rsp_type                rsp_beat;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   euler_rotate_points dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_beat(req_beat), .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor copy of the register file and the matrix it implies
   logic [15:0]        ang_a, ang_b, ang_g;
   logic signed [31:0] cen_x, cen_y;
   longint             rot_mat [3][3];

   rsp_type rotated_points [$];
   int      mismatches;
   int      points_sent;
   int      points_seen;
   int      idle_cycles;
   bit      burst_mode;

   // atan(2^-i) in turn units of 2^32
   longint atan_steps [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
      81, 41, 20, 10, 5, 3, 1
   };

   typedef struct {
      req_type pt;
      bit      typed;   // expected value typed into the row
      rsp_type res;
   } point_row_type;

   function automatic longint trig_q16(input longint v);
      longint r;
      r = (v + (64'sd1 <<< 13)) >>> 14;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r;
   endfunction

   function automatic void cordic_sincos(input logic [15:0] ang,
                                         output longint s, output longint c);
      logic [31:0] turn;
      longint      x, y, z, nx, cs, sn;
      turn = {ang, 16'h0000};
      z = longint'(turn[29:0]);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_steps[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_steps[i];
         end
         x = nx;
      end
      case (turn[31:30])
         2'd1: begin cs = -y; sn = x; end
         2'd2: begin cs = -x; sn = -y; end
         2'd3: begin cs = y; sn = -x; end
         default: begin cs = x; sn = y; end
      endcase
      c = trig_q16(cs);
      s = trig_q16(sn);
   endfunction

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 15)) >>> 16;
   endfunction

   function automatic void build_matrix();
      longint sa, ca, sb, cb, sg, cg;
      cordic_sincos(ang_a, sa, ca);
      cordic_sincos(ang_b, sb, cb);
      cordic_sincos(ang_g, sg, cg);
      rot_mat[0][0] = qmul(cb, cg);
      rot_mat[0][1] = -qmul(cb, sg);
      rot_mat[0][2] = sb;
      rot_mat[1][0] = qmul(qmul(cg, sa), sb) + qmul(ca, sg);
      rot_mat[1][1] = qmul(ca, cg) - qmul(qmul(sa, sb), sg);
      rot_mat[1][2] = -qmul(cb, sa);
      rot_mat[2][0] = qmul(sa, sg) - qmul(qmul(ca, cg), sb);
      rot_mat[2][1] = qmul(cg, sa) + qmul(qmul(ca, sb), sg);
      rot_mat[2][2] = qmul(ca, cb);
   endfunction

   function automatic logic [31:0] clamp_coord(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic rsp_type rotate_point(input req_type p);
      rsp_type r;
      longint  d [3];
      longint  acc [3];
      d[0] = longint'(p.px) - longint'(cen_x);
      d[1] = longint'(p.py) - longint'(cen_y);
      d[2] = longint'(p.pz);
      // products stay below 2^52, so the exact sum fits a longint
      for (int k = 0; k < 3; k++) begin
         acc[k] = (d[0] * rot_mat[k][0] + d[1] * rot_mat[k][1] + d[2] * rot_mat[k][2]
                   + (64'sd1 <<< 15)) >>> 16;
      end
      r.rx = clamp_coord(acc[0] + longint'(cen_x));
      r.ry = clamp_coord(acc[1] + longint'(cen_y));
      r.rz = clamp_coord(acc[2]);
      r.last_out = p.last_in;
      return r;
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2, 3: return $urandom;
         default: return 32'($signed($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
      endcase
   endfunction

   function automatic req_type random_point();
      req_type p;
      p.px = pick_coord();
      p.py = pick_coord();
      p.pz = pick_coord();
      p.last_in = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Check each result beat against the oldest pending expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         points_seen++;
         if (rotated_points.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result beat %h", $realtime, rsp_beat);
         end else begin
            rsp_type want;
            want = rotated_points.pop_front();
            if (want.rx !== rsp_beat.rx)
               $display("%0t: rx expected %h actual %h", $realtime, want.rx, rsp_beat.rx);
            if (want.ry !== rsp_beat.ry)
               $display("%0t: ry expected %h actual %h", $realtime, want.ry, rsp_beat.ry);
            if (want.rz !== rsp_beat.rz)
               $display("%0t: rz expected %h actual %h", $realtime, want.rz, rsp_beat.rz);
            if (want.last_out !== rsp_beat.last_out)
               $display("%0t: last_out expected %b actual %b", $realtime,
                        want.last_out, rsp_beat.last_out);
            if (want !== rsp_beat) mismatches++;
         end
      end
   end

   // Watchdog: count cycles with no beat moving in any direction
   always @(posedge clock) begin
      if (reset || rsp_strobe || csr_we || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $realtime,
                     rotated_points.size());
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Drive one point beat; start is left high so back-to-back beats need no toggle
   task automatic send_point(input req_type p, input bit typed, input rsp_type res);
      int gap;
      gap = 0;
      if (!burst_mode) begin
         case ($urandom_range(0, 19))
            0: gap = $urandom_range(20, 60);
            1, 2, 3, 4, 5: gap = $urandom_range(1, 4);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_beat <= p;
      do @(posedge clock); while (busy);
      // accepted at this edge: record what should come back
      rotated_points.push_back(typed ? res : rotate_point(p));
      points_sent++;
   endtask

   // Register writes happen only with the pipeline drained
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      start <= 1'b0;
      while (rotated_points.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ANGLE_ALPHA: ang_a = val[15:0];
         CSR_ANGLE_BETA:  ang_b = val[15:0];
         CSR_ANGLE_GAMMA: ang_g = val[15:0];
         CSR_CENTRE_X:    cen_x = val;
         CSR_CENTRE_Y:    cen_y = val;
         default: ;       // unknown index: drop
      endcase
      build_matrix();
   endtask

   task automatic write_setting(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] g, input logic [31:0] x,
                                input logic [31:0] y);
      write_reg(CSR_ANGLE_ALPHA, a);
      write_reg(CSR_ANGLE_BETA, b);
      write_reg(CSR_ANGLE_GAMMA, g);
      write_reg(CSR_CENTRE_X, x);
      write_reg(CSR_CENTRE_Y, y);
   endtask

   point_row_type point_table [$];
   rsp_type       no_res;

   task automatic add_row(input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic last);
      point_row_type row;
      row.pt  = '{px: x, py: y, pz: z, last_in: last};
      // at reset the matrix is identity and the centre is zero
      row.typed = 1'b1;
      row.res = '{rx: x, ry: y, rz: z, last_out: last};
      point_table.push_back(row);
   endtask

   initial begin
      logic [31:0] ext [4];
      int settings_done;
      mismatches  = 0;
      points_sent = 0;
      points_seen = 0;
      idle_cycles = 0;
      burst_mode  = 1'b0;
      no_res      = '0;
      start       = 1'b0;
      req_beat    = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      ang_a = '0; ang_b = '0; ang_g = '0; cen_x = '0; cen_y = '0;
      build_matrix();
      settings_done = 0;

      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows: extremes of every coordinate, last flag both ways
      add_row(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1);
      add_row(32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0);
      add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      add_row(32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000, 1'b0);

      foreach (point_table[i])
         send_point(point_table[i].pt, point_table[i].typed, point_table[i].res);
      settings_done++;

      // random rows of the same table under extreme settings: quarter turns,
      // wrapped angles, extreme centres that drive the sums into saturation
      ext[0] = 32'h0000_4000;
      ext[1] = 32'h0000_8000;
      ext[2] = 32'hFFFF_FFFF;
      ext[3] = 32'h0001_C000;
      for (int s = 0; s < 4; s++) begin
         write_setting(ext[s], ext[(s + 1) % 4], ext[(s + 2) % 4],
                       (s % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                       (s % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
         // unknown index must leave everything untouched
         write_reg(CSR_CENTRE_Y + 3'(s % 3 + 1), $urandom);
         for (int i = 0; i < 4; i++)
            send_point(point_table[$urandom_range(0, point_table.size() - 1)].pt,
                       1'b0, no_res);
         settings_done++;
      end

      // random settings; every fourth phase stays at an extreme
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph % 4 == 3)
            write_setting(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_0000,
                          32'h8000_0000, 32'h7FFF_FFFF);
         else
            write_setting($urandom, $urandom, $urandom,
                          (ph % 2) ? $urandom : 32'($urandom_range(0, 32'h00FF_FFFF)),
                          $urandom);
         settings_done++;
         for (int i = 0; i < PHASE_POINTS; i++) begin
            // stretches with and without idle gaps, chosen at random
            if (i % 25 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            send_point(random_point(), 1'b0, no_res);
         end
         burst_mode = 1'b0;
      end

      start <= 1'b0;
      while (rotated_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Rotated %0d points (%0d results checked) over %0d angle/centre settings,",
               points_sent, points_seen, settings_done);
      $display("including extreme coordinates, wrapped angles and saturating centres.");
      if (mismatches == 0 && points_seen == points_sent) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
